@@ rtl/dis_pkg.sv @@
// Shared constants and types of the distinct index sampler.
package dis_pkg;

  // Field widths fixed by the channel and register layout.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned LIMIT_W   = 18;
  localparam int unsigned TARGET_W  = 9;
  localparam int unsigned VALUE_W   = 17;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned CNT_OUT_W = 9;

  // Configuration port layout.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register indexes, taken from address bit 2.
  localparam logic REG_LIMIT  = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  // Register reset values.
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 18'd24646;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 9'd134;

  // Default sizes of the index table.
  localparam int unsigned DEF_MAX_TARGET = 256;
  localparam int unsigned DEF_INDEX_BITS = 17;

  // Classification of one queued item.
  typedef struct packed {
    logic is_start;
    logic valid;
  } dis_cls_t;

endpackage

@@ rtl/dis_if.sv @@
// Handshake channel interfaces for sampler items and sampler results.
interface dis_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [dis_pkg::WORD_W-1:0]    random_word;

  modport source (output valid, output mode, output random_word, input ready);
  modport sink   (input valid, input mode, input random_word, output ready);
endinterface

interface dis_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [dis_pkg::VALUE_W-1:0]    index_value;
  logic [dis_pkg::SLOT_W-1:0]     slot;
  logic [dis_pkg::CNT_OUT_W-1:0]  accepted_count;
  logic                           done_res;

  modport source (output valid, output accepted, output index_value, output slot,
                  output accepted_count, output done_res, input ready);
  modport sink   (input valid, input accepted, input index_value, input slot,
                  input accepted_count, input done_res, output ready);
endinterface

@@ rtl/dis_fifo.sv @@
// Two-entry queue between the classifying front and the scanning back.
module dis_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] data_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = data_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/dis_front.sv @@
// Front end: takes items, masks the random word and classifies the candidate.
module dis_front #(
  parameter int unsigned INDEX_BITS = dis_pkg::DEF_INDEX_BITS
) (
  dis_in_if.sink                      in_ch,
  input  logic [dis_pkg::LIMIT_W-1:0] limit_i,
  input  logic                        full_i,
  output logic                        push_o,
  output dis_pkg::dis_cls_t           cls_o,
  output logic [INDEX_BITS-1:0]       key_o
);

  localparam int unsigned XW = (INDEX_BITS > dis_pkg::LIMIT_W) ? INDEX_BITS
                                                               : dis_pkg::LIMIT_W;

  logic [dis_pkg::LIMIT_W-1:0] lim_mask;
  logic [dis_pkg::LIMIT_W-1:0] value;
  logic [XW-1:0]               value_x;
  logic                        fits;

  assign in_ch.ready = !full_i;
  assign push_o      = in_ch.valid && !full_i;

  // Mask of as many low ones as the limit has significant bits.
  always_comb begin
    for (int i = 0; i < dis_pkg::LIMIT_W; i++) begin
      lim_mask[i] = |(limit_i >> i);
    end
  end

  // A candidate must fit the table width and lie below the limit.
  assign value   = in_ch.random_word[dis_pkg::LIMIT_W-1:0] & lim_mask;
  assign fits    = ((value >> INDEX_BITS) == '0);
  assign value_x = XW'(value);

  // A start item carries a zero value.
  always_comb begin
    cls_o.is_start = !in_ch.mode;
    cls_o.valid    = in_ch.mode && fits && (value < limit_i);
    key_o          = in_ch.mode ? value_x[INDEX_BITS-1:0] : '0;
  end

endmodule

@@ rtl/dis_back.sv @@
// Back end: scans the index table for duplicates, stores new indices, builds results.
module dis_back #(
  parameter int unsigned MAX_TARGET = dis_pkg::DEF_MAX_TARGET,
  parameter int unsigned INDEX_BITS = dis_pkg::DEF_INDEX_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dis_pkg::TARGET_W-1:0] target_i,
  input  logic                         empty_i,
  input  dis_pkg::dis_cls_t            cls_i,
  input  logic [INDEX_BITS-1:0]        key_i,
  output logic                         pop_o,
  dis_out_if.source                    out_ch
);

  localparam int unsigned CW = $clog2(MAX_TARGET + 1);
  localparam int unsigned AW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int unsigned EW = (CW > dis_pkg::TARGET_W) ? CW : dis_pkg::TARGET_W;
  localparam int unsigned XW = (INDEX_BITS > dis_pkg::VALUE_W) ? INDEX_BITS
                                                               : dis_pkg::VALUE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state_q, state_d;
  dis_pkg::dis_cls_t       cls_q;
  logic [INDEX_BITS-1:0]   key_q;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           addr_q, addr_d;
  logic                    pend_q;
  logic                    dup_q, dup_d;
  logic [INDEX_BITS-1:0]   mem_q [MAX_TARGET];
  logic [INDEX_BITS-1:0]   rd_data_q;

  logic [EW-1:0]           tgt_e, count_e, count_d_e;
  logic                    need_scan, issue, fire, acc;
  logic [XW-1:0]           key_x;

  // Output register.
  logic                         out_valid_q;
  logic                         out_acc_q;
  logic [dis_pkg::VALUE_W-1:0]  out_value_q;
  logic [dis_pkg::SLOT_W-1:0]   out_slot_q;
  logic [dis_pkg::CNT_OUT_W-1:0] out_count_q;
  logic                         out_done_q;

  // Target clamped to the table depth.
  always_comb begin
    tgt_e = EW'(target_i);
    if (tgt_e > EW'(MAX_TARGET)) begin
      tgt_e = EW'(MAX_TARGET);
    end
  end

  assign count_e   = EW'(count_q);
  assign need_scan = !cls_q.is_start && cls_q.valid && (count_e < tgt_e);
  assign issue     = (state_q == ST_SCAN) && need_scan && (addr_q < count_q);
  assign fire      = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);
  assign acc       = need_scan && !dup_q;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign key_x     = XW'(key_q);
  assign count_d_e = EW'(count_d);

  // Sequencer: pop an item, walk the stored slots, then report.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    dup_d   = dup_q;
    count_d = count_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = ST_SCAN;
          addr_d  = '0;
          dup_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        dup_d = dup_q || (pend_q && (rd_data_q == key_q));
        if (issue) begin
          addr_d = addr_q + CW'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (cls_q.is_start) begin
          count_d = '0;
        end else if (acc) begin
          count_d = count_q + CW'(1);
        end
        if (!fire) begin
          count_d = count_q;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      pend_q  <= issue;
      dup_q   <= dup_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Current item and result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cls_q <= cls_i;
      key_q <= key_i;
    end
    if (fire) begin
      out_acc_q   <= acc && !cls_q.is_start;
      out_value_q <= key_x[dis_pkg::VALUE_W-1:0];
      out_slot_q  <= cls_q.is_start ? '0 : count_e[dis_pkg::SLOT_W-1:0];
      out_count_q <= count_d_e[dis_pkg::CNT_OUT_W-1:0];
      out_done_q  <= (count_d_e >= tgt_e);
    end
  end

  // Index table: one read per scan cycle, one write per stored index.
  always_ff @(posedge clk_i) begin
    if (fire && acc && !cls_q.is_start) begin
      mem_q[count_q[AW-1:0]] <= key_q;
    end
    if (issue) begin
      rd_data_q <= mem_q[addr_q[AW-1:0]];
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.accepted       = out_acc_q;
  assign out_ch.index_value    = out_value_q;
  assign out_ch.slot           = out_slot_q;
  assign out_ch.accepted_count = out_count_q;
  assign out_ch.done_res       = out_done_q;

endmodule

@@ rtl/distinct_index_sampler.sv @@
// Top level of the distinct index sampler: configuration registers and block wiring.
//
// Each item on the input channel yields one result. A start item (mode 0)
// clears the running count; a candidate item (mode 1) masks its random word to
// the bit length of index_limit and is stored when it lies below the limit,
// fits the table width, differs from every index stored in this sample and the
// count is still below target_count. The front end classifies items
// combinationally and parks them in a two-entry queue; the back end checks
// a candidate against the index table through a single read port, one stored
// entry per cycle; a start item, or a candidate rejected early, skips the scan.
// Results leave through an output register, so the block keeps working while
// a result waits. Registers are written over the APB-style port: index_limit
// at byte address 0 and target_count at byte address 4.
module distinct_index_sampler #(
  parameter int unsigned MAX_TARGET = dis_pkg::DEF_MAX_TARGET,
  parameter int unsigned INDEX_BITS = dis_pkg::DEF_INDEX_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dis_in_if.sink                         in_ch,
  dis_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dis_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dis_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dis_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned QW = INDEX_BITS + $bits(dis_pkg::dis_cls_t);

  logic [dis_pkg::LIMIT_W-1:0]  limit_q;
  logic [dis_pkg::TARGET_W-1:0] target_q;
  logic                         wr_en;
  logic                         reg_sel;

  logic                  push, pop, full, empty;
  dis_pkg::dis_cls_t     f_cls, b_cls;
  logic [INDEX_BITS-1:0] f_key, b_key;
  logic [QW-1:0]         q_wdata, q_rdata;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= dis_pkg::LIMIT_RESET;
      target_q <= dis_pkg::TARGET_RESET;
    end else if (wr_en) begin
      if (reg_sel == dis_pkg::REG_LIMIT) begin
        limit_q <= pwdata[dis_pkg::LIMIT_W-1:0];
      end else begin
        target_q <= pwdata[dis_pkg::TARGET_W-1:0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      dis_pkg::REG_LIMIT:  prdata = dis_pkg::APB_DATA_W'(limit_q);
      dis_pkg::REG_TARGET: prdata = dis_pkg::APB_DATA_W'(target_q);
      default:             prdata = '0;
    endcase
  end

  // Classifying front end.
  dis_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .in_ch   (in_ch),
    .limit_i (limit_q),
    .full_i  (full),
    .push_o  (push),
    .cls_o   (f_cls),
    .key_o   (f_key)
  );

  assign q_wdata        = {f_cls, f_key};
  assign {b_cls, b_key} = q_rdata;

  // Queue between front and back.
  dis_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (empty)
  );

  // Duplicate scan and result generation.
  dis_back #(
    .MAX_TARGET(MAX_TARGET),
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .target_i (target_q),
    .empty_i  (empty),
    .cls_i    (b_cls),
    .key_i    (b_key),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the distinct index sampler: directed table, random phases, APB setup.
module testbench;

  // Item modes on the input channel.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_CAND  = 1'b1;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic                          accepted;
    logic [dis_pkg::VALUE_W-1:0]   index_value;
    logic [dis_pkg::SLOT_W-1:0]    slot;
    logic [dis_pkg::CNT_OUT_W-1:0] accepted_count;
    logic                          done_res;
  } sample_result_t;

  // One row of the directed stimulus: either a register write or an item.
  typedef struct {
    bit             is_cfg;
    logic           reg_idx;
    logic           mode;
    logic [31:0]    data;
    bit             known;
    sample_result_t want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [dis_pkg::APB_ADDR_W-1:0] paddr;
  logic [dis_pkg::APB_DATA_W-1:0] pwdata;
  logic [dis_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  dis_in_if  in_ch ();
  dis_out_if out_ch ();

  distinct_index_sampler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: registers, stored indices and the running count.
  logic [dis_pkg::LIMIT_W-1:0]  limit_cfg  = dis_pkg::LIMIT_RESET;
  logic [dis_pkg::TARGET_W-1:0] target_cfg = dis_pkg::TARGET_RESET;
  logic [dis_pkg::LIMIT_W-1:0]  stored_idx [dis_pkg::DEF_MAX_TARGET];
  int unsigned                  held_count = 0;

  sample_result_t pending_outcomes [$];
  stim_row_t      directed_rows [$];
  int unsigned    mismatches   = 0;
  int unsigned    results_seen = 0;
  bit             tx_burst     = 1'b0;
  bit             rx_burst     = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Works out the result of one item and advances the shadow state.
  function automatic sample_result_t sample_outcome(input logic mode,
                                                    input logic [dis_pkg::WORD_W-1:0] word);
    int unsigned    eff_target;
    int unsigned    prior;
    int unsigned    nbits;
    logic [31:0]    mask;
    logic [31:0]    value;
    bit             fits;
    bit             seen;
    sample_result_t r;
    eff_target = (target_cfg > dis_pkg::DEF_MAX_TARGET) ? dis_pkg::DEF_MAX_TARGET
                                                         : target_cfg;
    prior = held_count;
    value = '0;
    r = '0;
    if (mode == MODE_START) begin
      held_count = 0;
      prior = 0;
    end else begin
      // The mask keeps as many low bits as the limit has significant bits.
      nbits = 0;
      for (int b = 0; b < dis_pkg::LIMIT_W; b++) begin
        if (limit_cfg[b]) nbits = b + 1;
      end
      mask = (32'h1 << nbits) - 32'h1;
      value = word & mask;
      fits = (value < limit_cfg) && (value < (32'h1 << dis_pkg::DEF_INDEX_BITS));
      seen = 1'b0;
      for (int i = 0; i < prior && i < dis_pkg::DEF_MAX_TARGET; i++) begin
        if (stored_idx[i] == value[dis_pkg::LIMIT_W-1:0]) seen = 1'b1;
      end
      if (fits && !seen && prior < eff_target && prior < dis_pkg::DEF_MAX_TARGET) begin
        stored_idx[prior] = value[dis_pkg::LIMIT_W-1:0];
        held_count = prior + 1;
        r.accepted = 1'b1;
      end
    end
    r.index_value    = value[dis_pkg::VALUE_W-1:0];
    r.slot           = dis_pkg::SLOT_W'(prior);
    r.accepted_count = dis_pkg::CNT_OUT_W'(held_count);
    r.done_res       = (held_count >= eff_target);
    return r;
  endfunction

  function automatic sample_result_t res(input int unsigned acc, input logic [31:0] val,
                                         input int unsigned slot, input int unsigned cnt,
                                         input int unsigned done);
    sample_result_t r;
    r.accepted       = 1'(acc);
    r.index_value    = val[dis_pkg::VALUE_W-1:0];
    r.slot           = dis_pkg::SLOT_W'(slot);
    r.accepted_count = dis_pkg::CNT_OUT_W'(cnt);
    r.done_res       = 1'(done);
    return r;
  endfunction

  function automatic void add_item(input logic mode, input logic [31:0] data,
                                   input bit known, input sample_result_t want);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = dis_pkg::REG_LIMIT;
    row.mode    = mode;
    row.data    = data;
    row.known   = known;
    row.want    = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic reg_idx, input logic [31:0] data);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_idx = reg_idx;
    row.mode    = MODE_START;
    row.data    = data;
    row.known   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endfunction

  // Idle length for one transaction; bursts with no idling come and go at random.
  function automatic int unsigned pick_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Offers one item and records its expected result once it is taken.
  task automatic offer_item(input logic mode, input logic [dis_pkg::WORD_W-1:0] word,
                            input bit known, input sample_result_t want);
    int unsigned    gap;
    sample_result_t predicted;
    gap = pick_wait(tx_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.random_word <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = sample_outcome(mode, word);
    pending_outcomes.push_back(known ? want : predicted);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Two-phase APB register write; the shadow register follows at the access edge.
  task automatic apb_write(input logic reg_idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == dis_pkg::REG_LIMIT) limit_cfg = value[dis_pkg::LIMIT_W-1:0];
    else target_cfg = value[dis_pkg::TARGET_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase: set both registers, then mostly runs of candidates with starts between.
  task automatic run_phase(input logic [31:0] limit, input logic [31:0] target,
                           input int unsigned n_items, input int unsigned start_odds);
    logic mode;
    wait_drained();
    apb_write(dis_pkg::REG_LIMIT, limit);
    apb_write(dis_pkg::REG_TARGET, target);
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_drained();
      mode = (start_odds != 0 && $urandom_range(0, start_odds - 1) == 0) ? MODE_START
                                                                       : MODE_CAND;
      offer_item(mode, $urandom, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, one long hold-off now and then, and the checks.
  initial begin : result_checker
    int unsigned    hold;
    sample_result_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = pick_wait(rx_burst);
      if (results_seen % 600 == 60) hold = 150;
      @(negedge clk_i);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0h", $time,
                 {out_ch.accepted, out_ch.index_value, out_ch.slot,
                  out_ch.accepted_count, out_ch.done_res});
      end else begin
        want = pending_outcomes.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_ch.accepted));
        check_field("index_value", 32'(want.index_value), 32'(out_ch.index_value));
        check_field("slot", 32'(want.slot), 32'(out_ch.slot));
        check_field("accepted_count", 32'(want.accepted_count),
                    32'(out_ch.accepted_count));
        check_field("done_res", 32'(want.done_res), 32'(out_ch.done_res));
      end
    end
  end

  // Stimulus side.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_START;
    in_ch.random_word = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    for (int i = 0; i < dis_pkg::DEF_MAX_TARGET; i++) stored_idx[i] = '0;

    // Reset values first: the limit's mask is 15 bits wide.
    add_item(MODE_START, 32'h0000_0000, 1'b1, res(0, 0, 0, 0, 0));
    add_item(MODE_CAND,  32'hffff_ffff, 1'b1, res(0, 32'h7fff, 0, 0, 0));
    add_item(MODE_CAND,  32'h0000_0000, 1'b1, res(1, 0, 0, 1, 0));
    add_item(MODE_CAND,  32'h0000_8000, 1'b1, res(0, 0, 1, 1, 0));
    add_item(MODE_CAND,  32'd24645,     1'b1, res(1, 24645, 1, 2, 0));
    add_item(MODE_CAND,  32'd24646,     1'b1, res(0, 24646, 2, 2, 0));
    add_item(MODE_CAND,  32'hffff_8005, 1'b0, '0);
    // A limit wider than the table: values past 17 bits are rejected.
    add_cfg(dis_pkg::REG_LIMIT, 32'h0003_ffff);
    add_item(MODE_CAND,  32'h0001_ffff, 1'b0, '0);
    add_item(MODE_CAND,  32'hfffe_0000, 1'b0, '0);
    // A zero limit masks everything away and rejects it.
    add_cfg(dis_pkg::REG_LIMIT, 32'h0000_0000);
    add_item(MODE_CAND,  32'hffff_ffff, 1'b1, res(0, 0, 4, 4, 0));
    // A limit equal to the table's index range, with a zero target: done right after the start.
    add_cfg(dis_pkg::REG_LIMIT, 32'd131072);
    add_cfg(dis_pkg::REG_TARGET, 32'd0);
    add_item(MODE_START, 32'h1234_5678, 1'b1, res(0, 0, 0, 0, 1));
    add_item(MODE_CAND,  32'h5555_5555, 1'b0, '0);
    // Saturation at a small target, then a target lowered below the count.
    add_cfg(dis_pkg::REG_TARGET, 32'd3);
    add_item(MODE_CAND,  32'h0000_0001, 1'b0, '0);
    add_item(MODE_CAND,  32'h0000_0002, 1'b0, '0);
    add_item(MODE_CAND,  32'h0000_0003, 1'b0, '0);
    add_item(MODE_CAND,  32'h0000_0004, 1'b0, '0);
    add_cfg(dis_pkg::REG_TARGET, 32'd1);
    add_item(MODE_CAND,  32'h0000_0007, 1'b0, '0);
    add_cfg(dis_pkg::REG_TARGET, 32'd256);
    add_item(MODE_CAND,  32'h0000_0009, 1'b0, '0);
    add_item(MODE_START, 32'hffff_ffff, 1'b1, res(0, 0, 0, 0, 0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        wait_drained();
        apb_write(directed_rows[r].reg_idx, directed_rows[r].data);
      end else begin
        offer_item(directed_rows[r].mode, directed_rows[r].data,
                   directed_rows[r].known, directed_rows[r].want);
      end
    end

    // Random phases: tiny limits give many duplicates, small targets saturate early.
    run_phase(32'd16, 32'd8, 150, 12);
    run_phase(32'd24646, 32'd134, 300, 150);
    // No starts and a target past the table size: the count runs to the top and slot wraps.
    run_phase(32'd511, 32'd511, 420, 0);
    run_phase(32'd3, 32'd2, 100, 5);
    run_phase(32'h0003_ffff, 32'd40, 250, 60);
    run_phase(32'd1, 32'd1, 60, 4);
    run_phase(32'd131072, 32'd64, 300, 80);
    for (int p = 0; p < 2; p++) begin
      int unsigned tgt;
      tgt = $urandom_range(1, 40);
      run_phase($urandom_range(1, 400), tgt, 80, tgt + 8);
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
